[sv/snc_pkg.sv]
`timescale 1ns / 1ps

package snc_pkg;

  localparam int unsigned NEST_LIMIT_DEF = 255;
  localparam int unsigned NUM_BRACKETS = 5;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] NOTE_B0   = 8'hE2;
  localparam logic [7:0] NOTE_B1   = 8'h99;
  localparam logic [7:0] NOTE_QTR  = 8'hA9;
  localparam logic [7:0] NOTE_8TH  = 8'hAA;
  localparam logic [7:0] NOTE_BEAM = 8'hAB;
  localparam logic [7:0] NOTE_16TH = 8'hAC;

  // openers: first byte in the low bits; closers: newest byte in the low bits
  localparam logic [23:0] OPEN_VAL [NUM_BRACKETS] = '{
    24'h00005B, 24'h000028, 24'h88BCEF, 24'h9080E3, 24'h8C80E3
  };
  localparam logic [23:0] CLOSE_VAL [NUM_BRACKETS] = '{
    24'h00005D, 24'h000029, 24'hEFBC89, 24'hE38091, 24'hE3808D
  };
  localparam logic [1:0] BRACKET_LEN [NUM_BRACKETS] = '{
    2'd1, 2'd1, 2'd3, 2'd3, 2'd3
  };

  typedef enum logic [1:0] {
    NOTE_IDLE  = 2'd0,
    NOTE_LEAD  = 2'd1,
    NOTE_MID   = 2'd2
  } note_prog_t;

  typedef struct packed {
    logic                       line_started;
    logic [23:0]                head_bytes;
    logic [1:0]                 head_count;
    logic [23:0]                recent_bytes;
    logic [1:0]                 recent_count;
    logic [23:0]                final_bytes;
    logic [1:0]                 final_count;
    logic [NUM_BRACKETS-1:0]    closer_found;
    logic                       notes_only;
    note_prog_t                 note_progress;
    logic                       colon_seen;
    logic                       text_after_colon;
    logic                       text_before_colon;
    logic                       lower_before_colon;
  } line_state_t;

  localparam line_state_t LINE_RESET = '{
    line_started:       1'b0,
    head_bytes:         24'd0,
    head_count:         2'd0,
    recent_bytes:       24'd0,
    recent_count:       2'd0,
    final_bytes:        24'd0,
    final_count:        2'd0,
    closer_found:       '0,
    notes_only:         1'b1,
    note_progress:      NOTE_IDLE,
    colon_seen:         1'b0,
    text_after_colon:   1'b0,
    text_before_colon:  1'b0,
    lower_before_colon: 1'b0
  };

  function automatic logic seq_match(input logic [23:0] bytes, input logic [1:0] count,
                                     input logic [1:0] len, input logic [23:0] val);
    logic hit;
    begin
      if (len == 2'd1) begin
        hit = (bytes[7:0] == val[7:0]);
      end else begin
        hit = (bytes == val);
      end
      seq_match = hit && (count >= len);
    end
  endfunction

endpackage

[sv/subtitle_noise_cue_classifier_top.sv]
`timescale 1ns / 1ps

// subtitle cue noise classifier: one byte request per cycle, with byte_valid low for an
// empty request; on the request flagged end_of_cue the open line is judged and one
// is_noise result is presented from the output register once the request leaves the
// input register, then all line and cue state returns to reset. throughput is one request
// per cycle while the input is not stalled, set by a single input register feeding the
// per-byte line state update; the input side stalls only while a cue-end request waits
// for the output register to be taken. markup depth counters saturate at NEST_LIMIT.
module subtitle_noise_cue_classifier_top #(
  parameter int unsigned NEST_LIMIT = snc_pkg::NEST_LIMIT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_text_byte,
  input  logic       in_byte_valid,
  input  logic       in_end_of_cue,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_is_noise
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_bv_r;
  logic       s1_eoc_r;

  logic out_valid_r, out_valid_nxt;
  logic out_is_noise_r, out_is_noise_nxt;

  snc_pkg::line_state_t line_r, line_nxt;
  snc_pkg::line_state_t line_clean;
  snc_pkg::line_state_t line_judged;
  logic any_real_r, any_real_nxt;

  logic out_free;
  logic advance;
  logic is_lf;
  logic line_done;
  logic keep;
  logic real_line;
  logic any_real_upd;

  assign out_free  = !out_valid_r || out_ready;
  assign advance   = s1_valid_r && (!s1_eoc_r || out_free);
  assign in_ready  = !s1_valid_r || advance;
  assign is_lf     = s1_bv_r && (s1_byte_r == snc_pkg::CH_LF);
  assign line_done = is_lf || s1_eoc_r;

  snc_markup #(
    .NEST_LIMIT (NEST_LIMIT)
  ) u_markup (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance && s1_bv_r),
    .line_clear (advance && line_done),
    .text_byte  (s1_byte_r),
    .keep       (keep)
  );

  snc_clean u_clean (
    .cur       (line_r),
    .keep      (keep && s1_bv_r),
    .text_byte (s1_byte_r),
    .nxt       (line_clean)
  );

  // a line feed judges the line as it stood before the byte
  assign line_judged = is_lf ? line_r : line_clean;

  snc_judge u_judge (
    .line      (line_judged),
    .real_line (real_line)
  );

  assign any_real_upd = any_real_r || (line_done && real_line);

  always_comb begin
    s1_valid_nxt     = s1_valid_r;
    line_nxt         = line_r;
    any_real_nxt     = any_real_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_is_noise_nxt = out_is_noise_r;
    if (in_ready) s1_valid_nxt = in_valid;
    if (advance) begin
      if (s1_eoc_r) begin
        line_nxt         = snc_pkg::LINE_RESET;
        any_real_nxt     = 1'b0;
        out_valid_nxt    = 1'b1;
        out_is_noise_nxt = !any_real_upd;
      end else if (is_lf) begin
        line_nxt     = snc_pkg::LINE_RESET;
        any_real_nxt = any_real_upd;
      end else begin
        line_nxt = line_clean;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      line_r      <= snc_pkg::LINE_RESET;
      any_real_r  <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      line_r      <= line_nxt;
      any_real_r  <= any_real_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_text_byte;
      s1_bv_r   <= in_byte_valid;
      s1_eoc_r  <= in_end_of_cue;
    end
    out_is_noise_r <= out_is_noise_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_is_noise = out_is_noise_r;

endmodule

[sv/snc_markup.sv]
`timescale 1ns / 1ps

module snc_markup #(
  parameter int unsigned NEST_LIMIT = snc_pkg::NEST_LIMIT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic       line_clear,
  input  logic [7:0] text_byte,
  output logic       keep
);

  localparam int unsigned DW = $clog2(NEST_LIMIT + 1);
  localparam logic [DW-1:0] LIMIT = DW'(NEST_LIMIT);

  logic [DW-1:0] angle_depth_r, angle_depth_nxt;
  logic [DW-1:0] brace_depth_r, brace_depth_nxt;
  logic          is_markup;

  assign is_markup = (text_byte == snc_pkg::CH_LT) || (text_byte == snc_pkg::CH_GT) ||
                     (text_byte == snc_pkg::CH_LBRACE) || (text_byte == snc_pkg::CH_RBRACE) ||
                     (text_byte == snc_pkg::CH_CR) || (text_byte == snc_pkg::CH_LF);

  assign keep = !is_markup && (angle_depth_r == '0) && (brace_depth_r == '0);

  always_comb begin
    angle_depth_nxt = angle_depth_r;
    brace_depth_nxt = brace_depth_r;
    if (line_clear) begin
      angle_depth_nxt = '0;
      brace_depth_nxt = '0;
    end else if (step) begin
      case (text_byte)
        snc_pkg::CH_LT: begin
          if (angle_depth_r < LIMIT) angle_depth_nxt = angle_depth_r + 1'b1;
        end
        snc_pkg::CH_GT: begin
          if (angle_depth_r != '0) angle_depth_nxt = angle_depth_r - 1'b1;
        end
        snc_pkg::CH_LBRACE: begin
          if (brace_depth_r < LIMIT) brace_depth_nxt = brace_depth_r + 1'b1;
        end
        snc_pkg::CH_RBRACE: begin
          if (brace_depth_r != '0) brace_depth_nxt = brace_depth_r - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_depth_r <= '0;
      brace_depth_r <= '0;
    end else begin
      angle_depth_r <= angle_depth_nxt;
      brace_depth_r <= brace_depth_nxt;
    end
  end

endmodule

[sv/snc_clean.sv]
`timescale 1ns / 1ps

module snc_clean (
  input  snc_pkg::line_state_t cur,
  input  logic                 keep,
  input  logic [7:0]           text_byte,
  output snc_pkg::line_state_t nxt
);

  logic blank;
  logic skip_lead;
  logic [23:0] recent_new;
  logic [1:0]  recent_cnt_new;

  assign blank = (text_byte == snc_pkg::CH_SPACE) || (text_byte == snc_pkg::CH_TAB);
  assign skip_lead = !cur.line_started && (blank || (text_byte == snc_pkg::CH_DASH));
  assign recent_new = {cur.recent_bytes[15:0], text_byte};
  assign recent_cnt_new = (cur.recent_count == 2'd3) ? 2'd3 : cur.recent_count + 2'd1;

  always_comb begin
    nxt = cur;
    if (keep && !skip_lead) begin
      nxt.line_started = 1'b1;
      // head capture, first byte lowest
      case (cur.head_count)
        2'd0: nxt.head_bytes[7:0]   = text_byte;
        2'd1: nxt.head_bytes[15:8]  = text_byte;
        2'd2: nxt.head_bytes[23:16] = text_byte;
        default: begin
        end
      endcase
      if (cur.head_count != 2'd3) nxt.head_count = cur.head_count + 2'd1;
      nxt.recent_bytes = recent_new;
      nxt.recent_count = recent_cnt_new;
      if (!blank) begin
        nxt.final_bytes = recent_new;
        nxt.final_count = recent_cnt_new;
      end
      for (int b = 0; b < snc_pkg::NUM_BRACKETS; b++) begin
        if (snc_pkg::seq_match(recent_new, recent_cnt_new, snc_pkg::BRACKET_LEN[b],
                               snc_pkg::CLOSE_VAL[b])) begin
          nxt.closer_found[b] = 1'b1;
        end
      end
      // music note tracking
      case (cur.note_progress)
        snc_pkg::NOTE_IDLE: begin
          if (text_byte == snc_pkg::NOTE_B0) begin
            nxt.note_progress = snc_pkg::NOTE_LEAD;
          end else if (!blank && text_byte != snc_pkg::CH_HASH &&
                       text_byte != snc_pkg::CH_STAR && text_byte != snc_pkg::CH_TILDE) begin
            nxt.notes_only = 1'b0;
          end
        end
        snc_pkg::NOTE_LEAD: begin
          if (text_byte == snc_pkg::NOTE_B1) begin
            nxt.note_progress = snc_pkg::NOTE_MID;
          end else begin
            nxt.notes_only    = 1'b0;
            nxt.note_progress = snc_pkg::NOTE_IDLE;
          end
        end
        default: begin
          if (!(text_byte == snc_pkg::NOTE_8TH || text_byte == snc_pkg::NOTE_BEAM ||
                text_byte == snc_pkg::NOTE_16TH || text_byte == snc_pkg::NOTE_QTR)) begin
            nxt.notes_only = 1'b0;
          end
          nxt.note_progress = snc_pkg::NOTE_IDLE;
        end
      endcase
      // speaker label tracking
      if (!cur.colon_seen) begin
        if (text_byte == snc_pkg::CH_COLON) begin
          nxt.colon_seen = 1'b1;
        end else begin
          if (!blank) nxt.text_before_colon = 1'b1;
          if (text_byte >= snc_pkg::CH_LOW_A && text_byte <= snc_pkg::CH_LOW_Z) begin
            nxt.lower_before_colon = 1'b1;
          end
        end
      end else if (!blank) begin
        nxt.text_after_colon = 1'b1;
      end
    end
  end

endmodule

[sv/snc_judge.sv]
`timescale 1ns / 1ps

module snc_judge (
  input  snc_pkg::line_state_t line,
  output logic                 real_line
);

  logic junk;
  logic starts;
  logic ends;

  always_comb begin
    junk = !line.line_started;
    if (line.notes_only && line.note_progress == snc_pkg::NOTE_IDLE) junk = 1'b1;
    for (int b = 0; b < snc_pkg::NUM_BRACKETS; b++) begin
      starts = snc_pkg::seq_match(line.head_bytes, line.head_count,
                                  snc_pkg::BRACKET_LEN[b], snc_pkg::OPEN_VAL[b]);
      ends   = snc_pkg::seq_match(line.final_bytes, line.final_count,
                                  snc_pkg::BRACKET_LEN[b], snc_pkg::CLOSE_VAL[b]);
      if (starts && (ends || !line.closer_found[b])) junk = 1'b1;
    end
    // all-caps speaker label
    if (line.colon_seen && !line.text_after_colon && line.text_before_colon &&
        !line.lower_before_colon) begin
      junk = 1'b1;
    end
    real_line = line.line_started && !junk;
  end

endmodule
